[hdl/bounded_word_stack_assert.svh]
// Assertion macros used by the word stack RTL.
`ifndef BOUNDED_WORD_STACK_ASSERT_SVH
`define BOUNDED_WORD_STACK_ASSERT_SVH

// Check a property on every rising edge of clk, skipped while rst_n is low.
`define BWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define BWS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/bws_pkg.sv]
// Shared widths and operation codes of the word stack.
`default_nettype none

package bws_pkg;

  localparam int KIND_W  = 3;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = 11;

  localparam logic [CNT_W-1:0] CAPACITY_RESET = 11'd1024;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 3'd0,
    KIND_POP   = 3'd1,
    KIND_DROP  = 3'd2,
    KIND_PEEK  = 3'd3,
    KIND_CLEAR = 3'd4
  } kind_t;

endpackage

`default_nettype wire

[hdl/bws_in_if.sv]
// Operation channel of the word stack: valid, ready and the operation payload.
`default_nettype none

interface bws_in_if;

  logic                             valid;
  logic                             ready;
  logic [bws_pkg::KIND_W-1:0]       kind;
  logic [bws_pkg::VALUE_W-1:0]      value;
  logic [bws_pkg::CNT_W-1:0]        count;

  modport source (output valid, output kind, output value, output count, input ready);
  modport sink   (input valid, input kind, input value, input count, output ready);

endinterface

`default_nettype wire

[hdl/bws_out_if.sv]
// Result channel of the word stack: valid, ready and the result payload.
`default_nettype none

interface bws_out_if;

  logic                             valid;
  logic                             ready;
  logic                             ok;
  logic [bws_pkg::VALUE_W-1:0]      data;
  logic [bws_pkg::CNT_W-1:0]        depth;
  logic [bws_pkg::CNT_W-1:0]        high_water;

  modport source (output valid, output ok, output data, output depth, output high_water,
                  input ready);
  modport sink   (input valid, input ok, input data, input depth, input high_water,
                  output ready);

endinterface

`default_nettype wire

[hdl/bws_ram.sv]
// Single-port synchronous RAM with registered read data.
`default_nettype none

module bws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

[hdl/bounded_word_stack.sv]
// Bounded word stack with high-water mark.
//
// in_chan (sink) carries one operation per transfer: kind (push, pop, drop,
// peek, clear), value for push and count for drop and peek. out_chan (source)
// returns one result per operation: ok, data (popped or peeked word, else
// zero), depth after the operation and the high-water mark.
// The words live in one single-port RAM; each operation makes at most one
// RAM access, issued in the cycle of its transfer, and depth and high-water
// registers update in that same cycle. An operation may be taken every cycle.
// Each result passes through the read stage, which holds it beside the registered
// RAM read data, and then through the output register.
// When out_chan stalls the result stage holds, then in_ready drops once the
// read stage behind it is also occupied; nothing is lost.
// cfg_we with cfg_wdata sets the capacity (limited to DEPTH), empties the
// stack and zeroes the high-water mark. Write it only while no operation is
// in flight.
// Reset (synchronous, rst_n low) empties the stack, zeroes the high-water
// mark and sets the capacity to 1024. The RAM is not cleared: only entries
// written by a push are ever read.
`default_nettype none
`include "bounded_word_stack_assert.svh"

module bounded_word_stack #(
  parameter int DEPTH     = 1024,
  parameter int WORD_BITS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  bws_in_if.sink                         in_chan,
  bws_out_if.source                      out_chan,
  input  wire logic                      cfg_we,
  input  wire logic [bws_pkg::CNT_W-1:0] cfg_wdata
);

  localparam int CW     = bws_pkg::CNT_W;
  localparam int VW     = bws_pkg::VALUE_W;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CW-1:0] cap_r;
  logic [CW-1:0] top_r, top_nxt;
  logic [CW-1:0] peak_r, peak_nxt;

  logic          s1_valid_r, s1_ok_r, s1_rd_r;
  logic [CW-1:0] s1_depth_r, s1_hw_r;

  logic          out_valid_r, out_ok_r;
  logic [VW-1:0] out_data_r;
  logic [CW-1:0] out_depth_r, out_hw_r;

  logic          s1_adv, accept;
  logic          ok_c, rd_c, we_c;
  logic [CW-1:0] ptr_c;
  logic [31:0]   ptr_w, lim_w, cap_w;

  logic [WORD_BITS-1:0] ram_rdata;
  logic [ADDR_W-1:0]    ram_addr;

  assign s1_adv        = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign accept        = in_chan.valid && in_chan.ready;

  // Effective capacity never exceeds the RAM depth.
  assign cap_w = 32'(cap_r);
  assign lim_w = (cap_w > 32'(DEPTH)) ? 32'(DEPTH) : cap_w;

  always_comb begin
    ok_c     = 1'b0;
    rd_c     = 1'b0;
    we_c     = 1'b0;
    ptr_c    = '0;
    top_nxt  = top_r;
    peak_nxt = peak_r;
    unique case (bws_pkg::kind_t'(in_chan.kind))
      bws_pkg::KIND_PUSH: begin
        if (32'(top_r) < lim_w) begin
          ok_c    = 1'b1;
          we_c    = 1'b1;
          ptr_c   = top_r;
          top_nxt = top_r + 1'b1;
          if (top_nxt > peak_r) begin
            peak_nxt = top_nxt;
          end
        end
      end
      bws_pkg::KIND_POP: begin
        if (top_r != '0) begin
          ok_c    = 1'b1;
          rd_c    = 1'b1;
          ptr_c   = top_r - 1'b1;
          top_nxt = top_r - 1'b1;
        end
      end
      bws_pkg::KIND_DROP: begin
        if (in_chan.count <= top_r) begin
          ok_c    = 1'b1;
          top_nxt = top_r - in_chan.count;
        end
      end
      bws_pkg::KIND_PEEK: begin
        if (in_chan.count != '0 && in_chan.count <= top_r) begin
          ok_c  = 1'b1;
          rd_c  = 1'b1;
          ptr_c = top_r - in_chan.count;
        end
      end
      bws_pkg::KIND_CLEAR: begin
        ok_c    = 1'b1;
        top_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign ptr_w    = 32'(ptr_c);
  assign ram_addr = ptr_w[ADDR_W-1:0];

  bws_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (accept && (we_c || rd_c)),
    .we    (we_c),
    .addr  (ram_addr),
    .wdata (WORD_BITS'(in_chan.value)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= bws_pkg::CAPACITY_RESET;
      top_r       <= '0;
      peak_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r  <= cfg_wdata;
        top_r  <= '0;
        peak_r <= '0;
      end else if (accept) begin
        top_r  <= top_nxt;
        peak_r <= peak_nxt;
      end

      // Read stage: holds the operation beside the registered RAM read data.
      if (accept) begin
        s1_valid_r <= 1'b1;
        s1_ok_r    <= ok_c;
        s1_rd_r    <= rd_c;
        s1_depth_r <= top_nxt;
        s1_hw_r    <= peak_nxt;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      // Output stage: advance when empty or the transfer completes.
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          out_ok_r    <= s1_ok_r;
          out_data_r  <= s1_rd_r ? VW'(ram_rdata) : '0;
          out_depth_r <= s1_depth_r;
          out_hw_r    <= s1_hw_r;
        end
      end
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.ok         = out_ok_r;
  assign out_chan.data       = out_data_r;
  assign out_chan.depth      = out_depth_r;
  assign out_chan.high_water = out_hw_r;

  `BWS_ASSERT(a_depth_le_peak, top_r <= peak_r, "depth above high-water mark")
  `BWS_ASSERT(a_depth_le_ram, 32'(top_r) <= 32'(DEPTH), "depth beyond RAM size")
  `BWS_ASSERT(a_pop_dec, (accept && !cfg_we && ok_c && in_chan.kind == bws_pkg::KIND_POP) |=> (top_r == $past(top_r) - 1'b1), "pop did not lower depth")

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the word stack: shadow stack, directed and random operations.
module tb_top;

  localparam int STACK_WORDS   = 1024;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [bws_pkg::CNT_W-1:0] CNT_MAX = '1;
  // Operation codes the block does not define
  localparam logic [bws_pkg::KIND_W-1:0] KIND_SPARE_A = 3'd5;
  localparam logic [bws_pkg::KIND_W-1:0] KIND_SPARE_B = 3'd6;
  localparam logic [bws_pkg::KIND_W-1:0] KIND_SPARE_C = 3'd7;

  typedef struct {
    logic [bws_pkg::KIND_W-1:0]  kind;
    logic [bws_pkg::VALUE_W-1:0] value;
    logic [bws_pkg::CNT_W-1:0]   count;
    bit                          wait_drain;
  } stack_op_t;

  typedef struct packed {
    logic                        ok;
    logic [bws_pkg::VALUE_W-1:0] data;
    logic [bws_pkg::CNT_W-1:0]   depth;
    logic [bws_pkg::CNT_W-1:0]   high_water;
  } stack_ans_t;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      cfg_we    = 1'b0;
  logic [bws_pkg::CNT_W-1:0] cfg_wdata = '0;

  bws_in_if  op_if ();
  bws_out_if ans_if ();

  bounded_word_stack dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (op_if),
    .out_chan (ans_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  logic [bws_pkg::VALUE_W-1:0] shadow_words [STACK_WORDS];
  int shadow_depth;
  int shadow_peak;
  int shadow_cap;

  stack_op_t  ops_to_send [$];
  stack_ans_t answers_due [$];
  stack_op_t  offered_op;
  bit send_idling;
  bit recv_idling;
  int send_gap;
  int recv_stall;
  int mismatches;
  int plan_depth;

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic stack_ans_t stack_apply(input stack_op_t op);
    stack_ans_t ans;
    int room;
    ans  = '0;
    room = (shadow_cap > STACK_WORDS) ? STACK_WORDS : shadow_cap;
    case (op.kind)
      bws_pkg::KIND_PUSH: begin
        if (shadow_depth < room) begin
          shadow_words[shadow_depth] = op.value;
          shadow_depth++;
          if (shadow_depth > shadow_peak) shadow_peak = shadow_depth;
          ans.ok = 1'b1;
        end
      end
      bws_pkg::KIND_POP: begin
        if (shadow_depth > 0) begin
          shadow_depth--;
          ans.data = shadow_words[shadow_depth];
          ans.ok   = 1'b1;
        end
      end
      bws_pkg::KIND_DROP: begin
        if (int'(op.count) <= shadow_depth) begin
          shadow_depth -= int'(op.count);
          ans.ok = 1'b1;
        end
      end
      bws_pkg::KIND_PEEK: begin
        if (op.count != '0 && int'(op.count) <= shadow_depth) begin
          ans.data = shadow_words[shadow_depth - int'(op.count)];
          ans.ok   = 1'b1;
        end
      end
      bws_pkg::KIND_CLEAR: begin
        shadow_depth = 0;
        ans.ok       = 1'b1;
      end
      default: ;
    endcase
    ans.depth      = shadow_depth[bws_pkg::CNT_W-1:0];
    ans.high_water = shadow_peak[bws_pkg::CNT_W-1:0];
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input logic [bws_pkg::VALUE_W-1:0] got,
                                 input logic [bws_pkg::VALUE_W-1:0] want);
    mismatches++;
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic check_answer();
    stack_ans_t want;
    if (answers_due.size() == 0) begin
      report_mismatch("result with none outstanding", ans_if.data, '0);
      return;
    end
    want = answers_due.pop_front();
    if (ans_if.ok !== want.ok)
      report_mismatch("ok", bws_pkg::VALUE_W'(ans_if.ok), bws_pkg::VALUE_W'(want.ok));
    if (ans_if.data !== want.data) report_mismatch("data", ans_if.data, want.data);
    if (ans_if.depth !== want.depth)
      report_mismatch("depth", bws_pkg::VALUE_W'(ans_if.depth),
                      bws_pkg::VALUE_W'(want.depth));
    if (ans_if.high_water !== want.high_water)
      report_mismatch("high_water", bws_pkg::VALUE_W'(ans_if.high_water),
                      bws_pkg::VALUE_W'(want.high_water));
  endtask

  // Driver: present queued operations, with gaps between transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      op_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (op_if.valid && op_if.ready) begin
        answers_due.push_back(stack_apply(offered_op));
        if (send_idling) send_gap = pick_gap();
      end
      if (!op_if.valid || op_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          op_if.valid <= 1'b0;
        end else if (ops_to_send.size() != 0 &&
                     !(ops_to_send[0].wait_drain && answers_due.size() != 0)) begin
          offered_op = ops_to_send.pop_front();
          op_if.valid <= 1'b1;
          op_if.kind  <= offered_op.kind;
          op_if.value <= offered_op.value;
          op_if.count <= offered_op.count;
        end else begin
          op_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take results, stalling at random
  always @(posedge clk) begin
    if (!rst_n) begin
      ans_if.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (ans_if.valid && ans_if.ready) check_answer();
      if (recv_stall > 0) begin
        recv_stall--;
        ans_if.ready <= 1'b0;
      end else begin
        ans_if.ready <= 1'b1;
        if (recv_idling) recv_stall = pick_gap();
      end
    end
  end

  task automatic queue_op(input logic [bws_pkg::KIND_W-1:0] kind,
                          input logic [bws_pkg::VALUE_W-1:0] value,
                          input logic [bws_pkg::CNT_W-1:0] count);
    stack_op_t op;
    op.kind       = kind;
    op.value      = value;
    op.count      = count;
    op.wait_drain = 1'b0;
    ops_to_send.push_back(op);
  endtask

  task automatic drain_stack();
    do @(negedge clk);
    while (ops_to_send.size() != 0 || op_if.valid || answers_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [bws_pkg::CNT_W-1:0] cap);
    drain_stack();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_cap   = int'(cap);
    shadow_depth = 0;
    shadow_peak  = 0;
    plan_depth   = 0;
  endtask

  // Mostly well-formed traffic aimed at the depth the stack should have, plus noise
  task automatic queue_random_ops(input int n, input int hold_at);
    stack_op_t op;
    int room;
    int roll;
    room = (shadow_cap > STACK_WORDS) ? STACK_WORDS : shadow_cap;
    for (int i = 0; i < n; i++) begin
      roll          = $urandom_range(99);
      op.kind       = bws_pkg::KIND_PUSH;
      op.value      = $urandom();
      op.count      = bws_pkg::CNT_W'($urandom_range(3));
      op.wait_drain = (i == hold_at);
      if (plan_depth == 0 && roll < 90) roll = 10;
      if (roll < 6) begin
        op.kind  = bws_pkg::KIND_W'($urandom_range(7));
        op.count = bws_pkg::CNT_W'($urandom_range(CNT_MAX));
      end else if (roll < 44) begin
        op.kind = bws_pkg::KIND_PUSH;
      end else if (roll < 66) begin
        op.kind = bws_pkg::KIND_POP;
      end else if (roll < 84) begin
        op.kind  = bws_pkg::KIND_PEEK;
        op.count = bws_pkg::CNT_W'($urandom_range(1, (plan_depth > 0) ? plan_depth : 1));
      end else if (roll < 90) begin
        op.kind  = bws_pkg::KIND_DROP;
        op.count = bws_pkg::CNT_W'($urandom_range((plan_depth < 3) ? plan_depth : 3));
      end else if (roll < 92) begin
        op.kind = bws_pkg::KIND_CLEAR;
      end else if (roll < 96) begin
        op.kind  = bws_pkg::KIND_PEEK;
        op.count = ($urandom_range(1) == 0) ? '0 :
                   bws_pkg::CNT_W'($urandom_range(plan_depth + 1, CNT_MAX));
      end else begin
        op.kind  = bws_pkg::KIND_DROP;
        op.count = bws_pkg::CNT_W'($urandom_range(plan_depth + 1, CNT_MAX));
      end
      case (op.kind)
        bws_pkg::KIND_PUSH:  if (plan_depth < room) plan_depth++;
        bws_pkg::KIND_POP:   if (plan_depth > 0) plan_depth--;
        bws_pkg::KIND_DROP:  if (int'(op.count) <= plan_depth) plan_depth -= int'(op.count);
        bws_pkg::KIND_CLEAR: plan_depth = 0;
        default: ;
      endcase
      ops_to_send.push_back(op);
    end
  endtask

  initial begin
    int caps [12] = '{1, 2, 3, 2047, 7, 16, 0, 64, 1024, 5, 300, 33};
    int waited;
    op_if.valid  = 1'b0;
    op_if.kind   = bws_pkg::KIND_PUSH;
    op_if.value  = '0;
    op_if.count  = '0;
    ans_if.ready = 1'b0;
    send_idling  = 1'b1;
    recv_idling  = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    shadow_cap   = int'(bws_pkg::CAPACITY_RESET);
    shadow_depth = 0;
    shadow_peak  = 0;

    // Empty stack, then three words (all ones, all zeros, a pattern), peeks, undefined codes, drops and clear
    queue_op(bws_pkg::KIND_POP, '0, '0);
    queue_op(bws_pkg::KIND_PEEK, '0, 11'd1);
    queue_op(bws_pkg::KIND_DROP, '0, '0);
    queue_op(bws_pkg::KIND_DROP, '0, 11'd1);
    queue_op(bws_pkg::KIND_PUSH, '1, '0);
    queue_op(bws_pkg::KIND_PUSH, '0, CNT_MAX);
    queue_op(bws_pkg::KIND_PUSH, 32'hA5A5_5A5A, '0);
    queue_op(bws_pkg::KIND_PEEK, '0, '0);
    queue_op(bws_pkg::KIND_PEEK, '0, 11'd1);
    queue_op(bws_pkg::KIND_PEEK, '0, 11'd3);
    queue_op(bws_pkg::KIND_PEEK, '0, 11'd4);
    queue_op(bws_pkg::KIND_PEEK, '0, CNT_MAX);
    queue_op(KIND_SPARE_A, '1, 11'd1);
    queue_op(KIND_SPARE_B, '1, CNT_MAX);
    queue_op(KIND_SPARE_C, '1, '0);
    queue_op(bws_pkg::KIND_POP, '0, '0);
    queue_op(bws_pkg::KIND_DROP, '0, CNT_MAX);
    queue_op(bws_pkg::KIND_DROP, '0, 11'd1);
    queue_op(bws_pkg::KIND_PUSH, 32'h0000_0001, '0);
    queue_op(bws_pkg::KIND_CLEAR, '0, '0);
    queue_op(bws_pkg::KIND_POP, '0, '0);
    // Zero capacity refuses every push; capacity one fills at once
    write_capacity('0);
    queue_op(bws_pkg::KIND_PUSH, 32'h1234_5678, '0);
    queue_op(bws_pkg::KIND_POP, '0, '0);
    write_capacity(11'd1);
    queue_op(bws_pkg::KIND_PUSH, 32'h8000_0000, '0);
    queue_op(bws_pkg::KIND_PUSH, 32'h7FFF_FFFF, '0);
    queue_op(bws_pkg::KIND_PEEK, '0, 11'd1);
    queue_op(bws_pkg::KIND_POP, '0, '0);

    for (int p = 0; p < 12; p++) begin
      write_capacity(bws_pkg::CNT_W'(caps[p]));
      send_idling = (p % 3) != 0;
      recv_idling = (p % 4) != 1;
      queue_random_ops(80, (p == 4) ? 40 : -1);
    end

    do @(negedge clk);
    while (ops_to_send.size() != 0 || op_if.valid);
    waited = 0;
    while (answers_due.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (answers_due.size() != 0)
      report_mismatch("results never returned", bws_pkg::VALUE_W'(answers_due.size()), '0);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
